// ===== sv/mwasm_pkg.sv =====
package mwasm_pkg;

	// datapath word; the ports stay at the full field width
	localparam int WORD_BITS  = 64;
	localparam int FIELD_BITS = 64;
	localparam int OPC_BITS   = 3;

	// multiplier split into two halves
	localparam int LO_BITS    = WORD_BITS / 2;
	localparam int HI_BITS    = WORD_BITS - LO_BITS;
	localparam int P00_BITS   = 2 * LO_BITS;
	localparam int P01_BITS   = LO_BITS + HI_BITS;
	localparam int P11_BITS   = 2 * HI_BITS;
	localparam int PROD_BITS  = 2 * WORD_BITS;

	// output queue; depth must be a power of two
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

	localparam logic [OPC_BITS-1:0] OP_ADD  = 3'd0;
	localparam logic [OPC_BITS-1:0] OP_SUB  = 3'd1;
	localparam logic [OPC_BITS-1:0] OP_MUL  = 3'd2;
	localparam logic [OPC_BITS-1:0] OP_CADD = 3'd3;
	localparam logic [OPC_BITS-1:0] OP_CSUB = 3'd4;
	localparam logic [OPC_BITS-1:0] OP_CNEG = 3'd5;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [OPC_BITS-1:0] mode;
		logic                cond;
		logic                first;
		logic                last;
	} ctl_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] result_word;
		logic [FIELD_BITS-1:0] carry_out;
		logic                  last_result;
	} out_item_t;

endpackage

// ===== sv/mwasm_in_if.sv =====
interface mwasm_in_if import mwasm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OPC_BITS-1:0]   opcode;
	logic                  first_word;
	logic                  last_word;
	logic [FIELD_BITS-1:0] x_word;
	logic [FIELD_BITS-1:0] y_word;
	logic                  cond_flag;

	modport source (output valid, opcode, first_word, last_word, x_word, y_word, cond_flag,
		input ready);
	modport sink (input valid, opcode, first_word, last_word, x_word, y_word, cond_flag,
		output ready);
endinterface

// ===== sv/mwasm_out_if.sv =====
interface mwasm_out_if import mwasm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [FIELD_BITS-1:0] result_word;
	logic [FIELD_BITS-1:0] carry_out;
	logic                  last_result;

	modport source (output valid, result_word, carry_out, last_result, input ready);
	modport sink (input valid, result_word, carry_out, last_result, output ready);
endinterface

// ===== sv/multiword_add_sub_mul_engine_top.sv =====
// Word-serial multiprecision add / sub / multiply-by-word / conditional add, sub and
// negate. Operand words go in least significant first, one item per clock while ready
// is high; first_word starts an operation and latches opcode, condition and multiplier,
// last_word closes it. Each input item gives one result item; the last word of a
// multiply gives a second item carrying the top carry word. Throughput is one input
// item per cycle while ready is high, set by the carry loop in the last stage (one
// W-bit add, or the low add plus high increment of the multiply-accumulate). From
// accept to result valid the item passes the input register, four half-width partial
// products, product sum, and the carry stage, which writes an eight-entry output queue.
// The queue space is reserved at accept, so ready drops when the sink stalls or when
// multiply ends, two result items each, arrive faster than one result per cycle.
module multiword_add_sub_mul_engine_top import mwasm_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	mwasm_in_if.sink    operand,
	mwasm_out_if.source result
);

	// operation state latched on first_word; carry_q holds the running carry
	logic [OPC_BITS-1:0] mode_q;
	logic                cond_q;
	word_t               mult_q;
	word_t               carry_q;

	logic                acc;
	logic [OPC_BITS-1:0] eff_mode;
	logic                eff_cond;
	word_t               x_in, y_in, eff_mult;
	logic [CNT_BITS-1:0] res_q;
	logic [CNT_BITS-1:0] weight;
	logic                pop;

	assign acc      = operand.valid && operand.ready;
	assign x_in     = operand.x_word[WORD_BITS-1:0];
	assign y_in     = operand.y_word[WORD_BITS-1:0];
	assign eff_mode = operand.first_word ? operand.opcode : mode_q;
	assign eff_cond = operand.first_word ? operand.cond_flag : cond_q;
	assign eff_mult = (operand.first_word && operand.opcode == OP_MUL) ? y_in : mult_q;
	assign weight   = (eff_mode == OP_MUL && operand.last_word) ? CNT_BITS'(2) : CNT_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			cond_q <= 1'b0;
			mult_q <= '0;
		end else if (acc && operand.first_word) begin
			mode_q <= operand.opcode;
			cond_q <= operand.cond_flag;
			if (operand.opcode == OP_MUL) begin
				mult_q <= y_in;
			end
		end
	end

	// stage 1: input register
	logic  v_s1;
	ctl_t  ctl_s1;
	word_t x_s1, y_s1, m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1 <= '{mode: eff_mode, cond: eff_cond, first: operand.first_word,
				last: operand.last_word};
			x_s1   <= x_in;
			y_s1   <= y_in;
			m_s1   <= eff_mult;
		end
	end

	// stage 2: partial products
	logic                v_s2;
	ctl_t                ctl_s2;
	word_t               x_s2, y_s2;
	logic [P00_BITS-1:0] p00_s2;
	logic [P01_BITS-1:0] p01_s2, p10_s2;
	logic [P11_BITS-1:0] p11_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			ctl_s2 <= ctl_s1;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			p00_s2 <= P00_BITS'(x_s1[LO_BITS-1:0]) * P00_BITS'(m_s1[LO_BITS-1:0]);
			p01_s2 <= P01_BITS'(x_s1[LO_BITS-1:0]) * P01_BITS'(m_s1[WORD_BITS-1:LO_BITS]);
			p10_s2 <= P01_BITS'(x_s1[WORD_BITS-1:LO_BITS]) * P01_BITS'(m_s1[LO_BITS-1:0]);
			p11_s2 <= P11_BITS'(x_s1[WORD_BITS-1:LO_BITS])
				* P11_BITS'(m_s1[WORD_BITS-1:LO_BITS]);
		end
	end

	// stage 3: full product x * m
	logic                 v_s3;
	ctl_t                 ctl_s3;
	word_t                x_s3, y_s3;
	logic [PROD_BITS-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			ctl_s3  <= ctl_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			prod_s3 <= PROD_BITS'(p00_s2)
				+ ((PROD_BITS'(p01_s2) + PROD_BITS'(p10_s2)) << LO_BITS)
				+ (PROD_BITS'(p11_s2) << (2 * LO_BITS));
		end
	end

	// carry stage: the only loop in the datapath
	word_t              c_in, c_nxt, r_word;
	logic [WORD_BITS:0] add_sum, sub_dif, neg_sum, mul_lo;
	word_t              mul_hi;
	logic               fin_bit;
	logic               two_items;
	out_item_t          item0, item1;

	assign c_in = ctl_s3.first
		? ((ctl_s3.mode == OP_CNEG) ? WORD_BITS'(ctl_s3.cond) : '0)
		: carry_q;

	assign add_sum = {1'b0, x_s3} + {1'b0, y_s3} + (WORD_BITS+1)'(c_in[0]);
	assign sub_dif = {1'b0, x_s3} - {1'b0, y_s3} - (WORD_BITS+1)'(c_in[0]);
	assign neg_sum = {1'b0, ~x_s3} + (WORD_BITS+1)'(c_in[0]);
	assign mul_lo  = {1'b0, prod_s3[WORD_BITS-1:0]} + {1'b0, c_in};
	assign mul_hi  = prod_s3[PROD_BITS-1:WORD_BITS] + WORD_BITS'(mul_lo[WORD_BITS]);

	always_comb begin
		r_word = x_s3;
		c_nxt  = c_in;
		case (ctl_s3.mode)
			OP_ADD: begin
				r_word = add_sum[WORD_BITS-1:0];
				c_nxt  = WORD_BITS'(add_sum[WORD_BITS]);
			end
			OP_SUB: begin
				r_word = sub_dif[WORD_BITS-1:0];
				c_nxt  = WORD_BITS'(sub_dif[WORD_BITS]);
			end
			OP_MUL: begin
				r_word = mul_lo[WORD_BITS-1:0];
				c_nxt  = mul_hi;
			end
			OP_CADD: begin
				r_word = ctl_s3.cond ? add_sum[WORD_BITS-1:0] : x_s3;
				c_nxt  = WORD_BITS'(add_sum[WORD_BITS]);
			end
			OP_CSUB: begin
				r_word = ctl_s3.cond ? sub_dif[WORD_BITS-1:0] : x_s3;
				c_nxt  = WORD_BITS'(sub_dif[WORD_BITS]);
			end
			OP_CNEG: begin
				r_word = ctl_s3.cond ? neg_sum[WORD_BITS-1:0] : x_s3;
				c_nxt  = WORD_BITS'(neg_sum[WORD_BITS]);
			end
			default: begin
				r_word = x_s3;
				c_nxt  = c_in;
			end
		endcase
	end

	always_comb begin
		case (ctl_s3.mode) inside
			OP_ADD, OP_SUB:           fin_bit = c_nxt[0];
			OP_CADD, OP_CSUB, OP_CNEG: fin_bit = c_nxt[0] & ctl_s3.cond;
			default:                  fin_bit = 1'b0;
		endcase
	end

	assign two_items = ctl_s3.last && ctl_s3.mode == OP_MUL;

	always_comb begin
		item0.result_word = FIELD_BITS'(r_word);
		item0.carry_out   = FIELD_BITS'(ctl_s3.last && fin_bit);
		item0.last_result = ctl_s3.last && !two_items;
		// top carry word of a multiply
		item1.result_word = FIELD_BITS'(c_nxt);
		item1.carry_out   = '0;
		item1.last_result = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else if (v_s3) begin
			carry_q <= c_nxt;
		end
	end

	// output queue; res_q counts queued items plus those still in the pipe
	out_item_t           fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q, n_push;

	assign n_push = v_s3 ? (two_items ? CNT_BITS'(2) : CNT_BITS'(1)) : '0;
	assign pop    = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (v_s3) begin
			fifo_q[wr_ptr_q] <= item0;
			if (two_items) begin
				fifo_q[wr_ptr_q + PTR_BITS'(1)] <= item1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			res_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			cnt_q <= cnt_q + n_push - (pop ? CNT_BITS'(1) : CNT_BITS'(0));
			res_q <= res_q + (acc ? weight : CNT_BITS'(0)) - (pop ? CNT_BITS'(1) : CNT_BITS'(0));
		end
	end

	// room for the worst case of two items
	assign operand.ready      = res_q <= CNT_BITS'(FIFO_DEPTH - 2);
	assign result.valid       = cnt_q != '0;
	assign result.result_word = fifo_q[rd_ptr_q].result_word;
	assign result.carry_out   = fifo_q[rd_ptr_q].carry_out;
	assign result.last_result = fifo_q[rd_ptr_q].last_result;

endmodule

// ===== sv/mwasm_checker.sv =====
module mwasm_checker import mwasm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic [FIELD_BITS-1:0] res_word,
	input logic [FIELD_BITS-1:0] res_carry,
	input logic                  res_last
);

	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word) && $stable(res_carry)
			&& $stable(res_last))
		else $error("result item changed while stalled");

	// queue comes out of reset empty
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// carry is only reported on the closing item
	a_carry_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> res_carry == '0)
		else $error("carry_out set on a non-final item");

	// final carry or borrow is a single bit
	a_carry_bit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_carry[FIELD_BITS-1:1] == '0)
		else $error("carry_out wider than one bit");

endmodule

bind multiword_add_sub_mul_engine_top mwasm_checker u_mwasm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_word  (result.result_word),
	.res_carry (result.carry_out),
	.res_last  (result.last_result)
);

// ===== verif/testbench.sv =====
module testbench import mwasm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OPC_BITS-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OPC_BITS-1:0] OP_RSVD7 = 3'd7;
	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 5;
	localparam int ITEM_TARGET  = 1200;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 12;
	localparam int LIMIT_NS     = 4_000_000;

	typedef logic [FIELD_BITS-1:0] field_t;

	logic clk = 1'b0;
	logic arst_n;

	mwasm_in_if  operand_if ();
	mwasm_out_if result_if ();

	multiword_add_sub_mul_engine_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_if),
		.result  (result_if)
	);

	always #CLK_HALF clk = ~clk;

	// engine state as seen by the predictor
	word_t               acc_carry;
	logic [OPC_BITS-1:0] op_mode;
	logic                op_cond;
	word_t               op_mult;

	out_item_t pending_results[$];

	int send_idle_pct;
	int stall_pct;
	bit hold_request;
	int hold_len;
	int items_sent;
	int results_checked;
	int operations;
	int errors;
	int ops_seen [8];

	task automatic report_mismatch(input string what, input field_t got, input field_t want);
		errors++;
		$display("[%0t] MISMATCH result #%0d %s: got %h expected %h",
			$time, results_checked, what, got, want);
	endtask

	// predicts the result items of one accepted word
	task automatic compute_word_results(input logic [OPC_BITS-1:0] opc, input logic first,
		input logic last, input field_t xin, input field_t yin, input logic cnd);
		word_t                 x, y, s, r, c;
		logic                  c1, c2;
		logic [2*WORD_BITS-1:0] prod;
		out_item_t             o;
		x = xin[WORD_BITS-1:0];
		y = yin[WORD_BITS-1:0];
		if (first) begin
			op_mode   = opc;
			op_cond   = cnd;
			acc_carry = '0;
			if (opc == OP_MUL)
				op_mult = y;
			if (opc == OP_CNEG)
				acc_carry = word_t'(cnd);
		end
		c = acc_carry;
		case (op_mode)
			OP_ADD, OP_CADD, OP_CNEG: begin
				if (op_mode == OP_CNEG) begin
					x = ~x;
					y = '0;
				end
				s  = x + y;
				c1 = (s < x);
				r  = s + c;
				c2 = (r < s);
				c  = word_t'(c1 | c2);
				if (op_mode == OP_CNEG)
					x = ~x;
			end
			OP_SUB, OP_CSUB: begin
				s  = x - y;
				c1 = (x < y);
				r  = s - c;
				c2 = (s < c);
				c  = word_t'(c1 | c2);
			end
			OP_MUL: begin
				prod = {{WORD_BITS{1'b0}}, x} * {{WORD_BITS{1'b0}}, op_mult}
					+ {{WORD_BITS{1'b0}}, c};
				r = prod[WORD_BITS-1:0];
				c = prod[2*WORD_BITS-1:WORD_BITS];
			end
			default: r = x;
		endcase
		if ((op_mode == OP_CADD || op_mode == OP_CSUB || op_mode == OP_CNEG) && !op_cond)
			r = x;
		acc_carry = c;

		o.result_word = field_t'(r);
		o.carry_out   = '0;
		o.last_result = 1'b0;
		if (last) begin
			if (op_mode == OP_MUL) begin
				pending_results.push_back(o);
				o.result_word = field_t'(c);
			end else if (op_mode == OP_ADD || op_mode == OP_SUB) begin
				o.carry_out = field_t'(c[0]);
			end else if (op_mode == OP_CADD || op_mode == OP_CSUB || op_mode == OP_CNEG) begin
				o.carry_out = field_t'(c[0] & op_cond);
			end
			o.last_result = 1'b1;
		end
		pending_results.push_back(o);
	endtask

	task automatic send_word(input logic [OPC_BITS-1:0] opc, input logic first,
		input logic last, input field_t x, input field_t y, input logic cnd);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			operand_if.valid <= 1'b0;
			@(negedge clk);
		end
		operand_if.valid      <= 1'b1;
		operand_if.opcode     <= opc;
		operand_if.first_word <= first;
		operand_if.last_word  <= last;
		operand_if.x_word     <= x;
		operand_if.y_word     <= y;
		operand_if.cond_flag  <= cnd;
		do
			@(posedge clk);
		while (!operand_if.ready);
		compute_word_results(opc, first, last, x, y, cnd);
		items_sent++;
		if (first)
			ops_seen[opc]++;
	endtask

	function automatic field_t pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return field_t'(1);
			3: return {1'b1, {(FIELD_BITS-1){1'b0}}};
			4: return field_t'($urandom_range(0, 15));
			5: return ~field_t'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// one operation; a few are broken on purpose: no start or no end marker
	task automatic run_operation();
		int                  n;
		int                  shape;
		logic [OPC_BITS-1:0] opc;
		logic                cnd;
		logic                first;
		logic                last;
		n     = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
		shape = $urandom_range(0, 19);
		opc   = ($urandom_range(0, 19) == 0) ? OPC_BITS'($urandom_range(OP_RSVD6, OP_RSVD7))
			: OPC_BITS'($urandom_range(OP_ADD, OP_CNEG));
		cnd   = 1'($urandom_range(0, 1));
		operations++;
		for (int i = 0; i < n; i++) begin
			first = (i == 0) && (shape != 0);
			last  = (i == n - 1) && (shape != 1);
			// opcode and condition are don't-care past the start; randomize them
			if (first)
				send_word(opc, first, last, pick_word(), pick_word(), cnd);
			else
				send_word(OPC_BITS'($urandom_range(0, 7)), first, last, pick_word(),
					pick_word(), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_directed();
		// words before any start: an add with zero carry
		send_word(OP_RSVD7, 1'b0, 1'b0, '1, field_t'(1), 1'b1);
		send_word(OP_SUB, 1'b0, 1'b1, '0, '0, 1'b0);
		send_word(OP_ADD, 1'b1, 1'b1, '1, '1, 1'b0);
		send_word(OP_SUB, 1'b1, 1'b0, '0, field_t'(1), 1'b0);
		send_word(OP_ADD, 1'b0, 1'b1, '0, '0, 1'b0);
		send_word(OP_MUL, 1'b1, 1'b0, '1, '1, 1'b0);
		send_word(OP_ADD, 1'b0, 1'b1, '1, '0, 1'b0);
		send_word(OP_MUL, 1'b1, 1'b1, '1, '0, 1'b1);
		send_word(OP_CADD, 1'b1, 1'b1, '1, field_t'(1), 1'b1);
		send_word(OP_CADD, 1'b1, 1'b1, '1, field_t'(1), 1'b0);
		send_word(OP_CSUB, 1'b1, 1'b1, '0, '1, 1'b1);
		send_word(OP_CSUB, 1'b1, 1'b1, '0, '1, 1'b0);
		send_word(OP_CNEG, 1'b1, 1'b0, '0, '1, 1'b1);
		send_word(OP_CNEG, 1'b0, 1'b1, '0, '1, 1'b0);
		send_word(OP_CNEG, 1'b1, 1'b1, field_t'(5), '0, 1'b0);
		send_word(OP_CNEG, 1'b1, 1'b1, {1'b1, {(FIELD_BITS-1){1'b0}}}, '0, 1'b1);
		send_word(OP_RSVD6, 1'b1, 1'b1, '1, '1, 1'b1);
		send_word(OP_RSVD7, 1'b1, 1'b0, field_t'(7), '1, 1'b0);
		send_word(OP_ADD, 1'b0, 1'b1, field_t'(9), '1, 1'b1);
		// word after an end marker keeps the latched unused mode
		send_word(OP_SUB, 1'b0, 1'b1, '1, '1, 1'b0);
		send_word(OP_MUL, 1'b1, 1'b1, '1, field_t'(2), 1'b0);
		// multiply continued past its end: carries the top word along
		send_word(OP_ADD, 1'b0, 1'b1, field_t'(1), '0, 1'b0);
		send_word(OP_ADD, 1'b1, 1'b1, '0, '0, 1'b1);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall, input int quota);
		int stop_at;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		stop_at       = items_sent + quota;
		while (items_sent < stop_at)
			run_operation();
	endtask

	// receiver holds off while multiplies stream in, so the output queue fills
	task automatic test_backpressure();
		int stop_at;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_len      = HOLD_CYCLES;
		hold_request  = 1'b1;
		stop_at       = items_sent + 40;
		while (items_sent < stop_at) begin
			operations++;
			send_word(OP_MUL, 1'b1, 1'b0, pick_word(), pick_word(), 1'b0);
			send_word(OP_MUL, 1'b0, 1'b1, pick_word(), pick_word(), 1'b0);
		end
	endtask

	// receiver side: random stalls, plus a long hold-off on request
	initial begin : drive_result_ready
		int hold_left;
		hold_left       = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left    = hold_len;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected item", result_if.result_word, '0);
			end else begin
				want = pending_results.pop_front();
				if (result_if.result_word !== want.result_word)
					report_mismatch("result_word", result_if.result_word, want.result_word);
				if (result_if.carry_out !== want.carry_out)
					report_mismatch("carry_out", result_if.carry_out, want.carry_out);
				if (result_if.last_result !== want.last_result)
					report_mismatch("last_result", field_t'(result_if.last_result),
						field_t'(want.last_result));
			end
			results_checked++;
		end
	end

	initial begin : watchdog
		#LIMIT_NS;
		$display("Timeout at %0t with %0d items outstanding", $time, pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin : main
		arst_n                = 1'b0;
		operand_if.valid      = 1'b0;
		operand_if.opcode     = OP_ADD;
		operand_if.first_word = 1'b0;
		operand_if.last_word  = 1'b0;
		operand_if.x_word     = '0;
		operand_if.y_word     = '0;
		operand_if.cond_flag  = 1'b0;
		acc_carry             = '0;
		op_mode               = OP_ADD;
		op_cond               = 1'b0;
		op_mult               = '0;
		send_idle_pct         = 0;
		stall_pct             = 0;
		hold_request          = 1'b0;
		hold_len              = 0;
		items_sent            = 0;
		results_checked       = 0;
		operations            = 0;
		errors                = 0;
		foreach (ops_seen[i])
			ops_seen[i] = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_phase(0, 0, 280);
		test_backpressure();
		test_random_phase(80, 0, 280);
		test_random_phase(0, 80, 280);
		test_random_phase(18, 18, ITEM_TARGET - items_sent);

		@(negedge clk);
		operand_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d operand items in %0d random operations plus directed cases;",
			items_sent, operations);
		$display("starts add/sub/mul/cadd/csub/cneg/unused %0d/%0d/%0d/%0d/%0d/%0d/%0d, %0d results",
			ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3], ops_seen[4], ops_seen[5],
			ops_seen[6] + ops_seen[7], results_checked);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
